@@ hw/rtl/dlm_pkg.sv @@
// ----------------------------------------------------------------------------
// dlm_pkg
// Shared types and constants of the dense layer multiply-accumulate engine.
// ----------------------------------------------------------------------------
package dlm_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_RELU_ENABLE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ARGMAX_ENABLE = 2'd1;

    // datapath widths
    localparam int DATA_W  = 16;
    localparam int BIAS_W  = 32;
    localparam int PROD_W  = 32;
    localparam int ACC_W   = 40;
    localparam int INDEX_W = 8;

    // accumulator saturation bounds
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // output saturation bounds
    localparam logic signed [DATA_W-1:0] OUT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] OUT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // half an output lsb in Q16.16
    localparam logic signed [ACC_W:0] ROUND_HALF = 41'sd128;

    // term queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one classified term passed from front to back
    typedef struct packed {
        logic signed [PROD_W-1:0] prod;
        logic signed [BIAS_W-1:0] bias;
        logic                     first_term;
        logic                     last_term;
        logic                     last_neuron;
    } term_t;

    // queue status toward front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

@@ hw/rtl/dlm_if.sv @@
// ----------------------------------------------------------------------------
// dlm_if
// Valid/ready channels for input terms and neuron results.
// ----------------------------------------------------------------------------
interface dlm_term_if;
    logic                               valid;
    logic                               ready;
    logic signed [dlm_pkg::DATA_W-1:0]  activation;
    logic signed [dlm_pkg::DATA_W-1:0]  weight;
    logic signed [dlm_pkg::BIAS_W-1:0]  bias;
    logic                               first_term;
    logic                               last_term;
    logic                               last_neuron;

    modport source (
        output valid, activation, weight, bias, first_term, last_term, last_neuron,
        input  ready
    );
    modport sink (
        input  valid, activation, weight, bias, first_term, last_term, last_neuron,
        output ready
    );
endinterface

interface dlm_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [dlm_pkg::DATA_W-1:0]  neuron_value;
    logic        [dlm_pkg::INDEX_W-1:0] neuron_index;
    logic        [dlm_pkg::INDEX_W-1:0] predicted_class;
    logic                               class_valid;

    modport source (
        output valid, neuron_value, neuron_index, predicted_class, class_valid,
        input  ready
    );
    modport sink (
        input  valid, neuron_value, neuron_index, predicted_class, class_valid,
        output ready
    );
endinterface

@@ hw/rtl/dlm_front.sv @@
// ----------------------------------------------------------------------------
// dlm_front
// Accepts terms, forms the activation-weight product and classifies the term.
// ----------------------------------------------------------------------------
module dlm_front (
    input  logic                 clk,
    input  logic                 rst_n,
    dlm_term_if.sink             terms,
    input  dlm_pkg::q_stat_t     q_stat,
    output logic                 push,
    output dlm_pkg::term_t       push_data
);

    logic                                 valid_reg;
    logic                                 valid_next;
    dlm_pkg::term_t                       data_reg;
    logic signed [dlm_pkg::PROD_W-1:0]    prod;
    logic                                 take;

    // product of the incoming term
    assign prod = terms.activation * terms.weight;

    // hand the staged term to the queue when there is room
    assign push        = valid_reg && !q_stat.full;
    assign terms.ready = !valid_reg || !q_stat.full;
    assign take        = terms.valid && terms.ready;
    assign push_data   = data_reg;

    // stage occupancy
    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // staged term payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg.prod        <= prod;
            data_reg.bias        <= terms.bias;
            data_reg.first_term  <= terms.first_term;
            data_reg.last_term   <= terms.last_term;
            data_reg.last_neuron <= terms.last_neuron;
        end
    end

endmodule

@@ hw/rtl/dlm_queue.sv @@
// ----------------------------------------------------------------------------
// dlm_queue
// Short term queue that decouples the front from the accumulate back end.
// ----------------------------------------------------------------------------
module dlm_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  dlm_pkg::term_t       push_data,
    input  logic                 pop,
    output dlm_pkg::term_t       head,
    output dlm_pkg::q_stat_t     q_stat
);

    dlm_pkg::term_t                   mem [dlm_pkg::QUEUE_DEPTH];
    logic [dlm_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [dlm_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [dlm_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [dlm_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [dlm_pkg::QCNT_W-1:0]       count_reg;
    logic [dlm_pkg::QCNT_W-1:0]       count_next;

    localparam logic [dlm_pkg::QPTR_W-1:0] LAST_SLOT =
        dlm_pkg::QPTR_W'(dlm_pkg::QUEUE_DEPTH - 1);
    localparam logic [dlm_pkg::QCNT_W-1:0] FULL_COUNT =
        dlm_pkg::QCNT_W'(dlm_pkg::QUEUE_DEPTH);

    assign head         = mem[rd_ptr_reg];
    assign q_stat.full  = (count_reg == FULL_COUNT);
    assign q_stat.empty = (count_reg == '0);

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage write
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/dlm_back.sv @@
// ----------------------------------------------------------------------------
// dlm_back
// Saturating accumulate, Q8.8 rounding, ReLU, argmax and result register.
// ----------------------------------------------------------------------------
module dlm_back #(
    parameter int unsigned COUNT_LIMIT = 255
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dlm_pkg::q_stat_t     q_stat,
    input  dlm_pkg::term_t       head,
    output logic                 pop,
    input  logic                 relu_en,
    input  logic                 argmax_en,
    dlm_result_if.source         results
);

    localparam logic [dlm_pkg::INDEX_W-1:0] LIMIT = dlm_pkg::INDEX_W'(COUNT_LIMIT);

    // accumulate stage
    logic signed [dlm_pkg::ACC_W-1:0]   acc_reg;
    logic signed [dlm_pkg::ACC_W:0]     acc_base;
    logic signed [dlm_pkg::ACC_W:0]     acc_sum;
    logic signed [dlm_pkg::ACC_W-1:0]   acc_next;

    // finished neuron stage
    logic                               r_valid_reg;
    logic                               r_valid_next;
    logic signed [dlm_pkg::ACC_W-1:0]   r_acc_reg;
    logic                               r_last_n_reg;
    logic                               r_ready;

    // output stage
    logic signed [dlm_pkg::ACC_W:0]     rnd_sum;
    logic signed [32:0]                 rnd_shift;
    logic signed [dlm_pkg::DATA_W-1:0]  val_sat;
    logic signed [dlm_pkg::DATA_W-1:0]  val;
    logic                               better;
    logic                               o_load;
    logic                               o_valid_reg;
    logic                               o_valid_next;
    logic signed [dlm_pkg::DATA_W-1:0]  o_value_reg;
    logic [dlm_pkg::INDEX_W-1:0]        o_index_reg;
    logic [dlm_pkg::INDEX_W-1:0]        o_class_reg;
    logic                               o_class_valid_reg;

    // layer state
    logic [dlm_pkg::INDEX_W-1:0]        count_reg;
    logic [dlm_pkg::INDEX_W-1:0]        count_next;
    logic signed [dlm_pkg::DATA_W-1:0]  best_value_reg;
    logic [dlm_pkg::INDEX_W-1:0]        best_index_reg;

    // saturating multiply-accumulate
    always_comb
    begin
        if (head.first_term)
        begin
            acc_base = {{(dlm_pkg::ACC_W + 1 - dlm_pkg::BIAS_W){head.bias[dlm_pkg::BIAS_W-1]}},
                        head.bias};
        end
        else
        begin
            acc_base = {acc_reg[dlm_pkg::ACC_W-1], acc_reg};
        end
        acc_sum = acc_base
                + {{(dlm_pkg::ACC_W + 1 - dlm_pkg::PROD_W){head.prod[dlm_pkg::PROD_W-1]}},
                   head.prod};
        if (acc_sum[dlm_pkg::ACC_W] != acc_sum[dlm_pkg::ACC_W-1])
        begin
            acc_next = acc_sum[dlm_pkg::ACC_W] ? dlm_pkg::ACC_MIN : dlm_pkg::ACC_MAX;
        end
        else
        begin
            acc_next = acc_sum[dlm_pkg::ACC_W-1:0];
        end
    end

    // stage handshakes
    assign o_load  = r_valid_reg && (!o_valid_reg || results.ready);
    assign r_ready = !r_valid_reg || o_load;
    assign pop     = !q_stat.empty && (!head.last_term || r_ready);

    always_comb
    begin
        r_valid_next = r_valid_reg;
        if (pop && head.last_term)
        begin
            r_valid_next = 1'b1;
        end
        else if (o_load)
        begin
            r_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        o_valid_next = o_valid_reg;
        if (o_load)
        begin
            o_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            o_valid_next = 1'b0;
        end
    end

    // round Q16.16 to Q8.8 half up, saturate, relu
    always_comb
    begin
        rnd_sum   = {r_acc_reg[dlm_pkg::ACC_W-1], r_acc_reg} + dlm_pkg::ROUND_HALF;
        rnd_shift = rnd_sum[dlm_pkg::ACC_W:8];
        if (rnd_shift[32:15] != {18{rnd_shift[32]}})
        begin
            val_sat = rnd_shift[32] ? dlm_pkg::OUT_MIN : dlm_pkg::OUT_MAX;
        end
        else
        begin
            val_sat = rnd_shift[15:0];
        end
        if (relu_en && val_sat[dlm_pkg::DATA_W-1])
        begin
            val = '0;
        end
        else
        begin
            val = val_sat;
        end
        better = (count_reg == '0) || (val > best_value_reg);
    end

    // neuron position within the layer
    always_comb
    begin
        count_next = count_reg;
        if (r_last_n_reg)
        begin
            count_next = '0;
        end
        else if (count_reg < LIMIT)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    // control and layer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            r_valid_reg    <= 1'b0;
            o_valid_reg    <= 1'b0;
            count_reg      <= '0;
            best_value_reg <= '0;
            best_index_reg <= '0;
        end
        else
        begin
            r_valid_reg <= r_valid_next;
            o_valid_reg <= o_valid_next;
            if (pop)
            begin
                acc_reg <= acc_next;
            end
            if (o_load)
            begin
                count_reg <= count_next;
                if (argmax_en && better)
                begin
                    best_value_reg <= val;
                    best_index_reg <= count_reg;
                end
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (pop && head.last_term)
        begin
            r_acc_reg    <= acc_next;
            r_last_n_reg <= head.last_neuron;
        end
        if (o_load)
        begin
            o_value_reg       <= val;
            o_index_reg       <= count_reg;
            o_class_reg       <= !argmax_en ? '0 : (better ? count_reg : best_index_reg);
            o_class_valid_reg <= argmax_en && r_last_n_reg;
        end
    end

    assign results.valid           = o_valid_reg;
    assign results.neuron_value    = o_value_reg;
    assign results.neuron_index    = o_index_reg;
    assign results.predicted_class = o_class_reg;
    assign results.class_valid     = o_class_valid_reg;

endmodule

@@ hw/rtl/dense_layer_mac_relu_argmax.sv @@
// ----------------------------------------------------------------------------
// dense_layer_mac_relu_argmax
// Streaming fully connected layer: multiply-accumulate, ReLU and argmax.
// ----------------------------------------------------------------------------
// Throughput: one term per cycle unless the term queue fills, set by the
// accumulate register loop. A last term reaches results.valid through the
// front stage register, term queue, finished neuron register and output register.
// The 4-entry term queue takes up short result stalls; a longer one stops the
// input once seven single-term neurons are held.
// Reset clears accumulator, count and argmax state; relu_enable 1, argmax_enable 0.
module dense_layer_mac_relu_argmax #(
    parameter int unsigned MAX_NEURONS = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    dlm_term_if.sink                              terms,
    dlm_result_if.source                          results,
    input  logic                                  cfg_we,
    input  logic [dlm_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [dlm_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int unsigned COUNT_LIMIT = (MAX_NEURONS - 1 < 255) ? MAX_NEURONS - 1 : 255;

    logic                relu_en_reg;
    logic                argmax_en_reg;
    logic                q_push;
    logic                q_pop;
    dlm_pkg::term_t      q_push_data;
    dlm_pkg::term_t      q_head;
    dlm_pkg::q_stat_t    q_stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relu_en_reg   <= 1'b1;
            argmax_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dlm_pkg::CFG_RELU_ENABLE:   relu_en_reg   <= cfg_data[0];
                dlm_pkg::CFG_ARGMAX_ENABLE: argmax_en_reg <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    // front: accept and multiply
    dlm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .terms     (terms),
        .q_stat    (q_stat),
        .push      (q_push),
        .push_data (q_push_data)
    );

    // term queue
    dlm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head      (q_head),
        .q_stat    (q_stat)
    );

    // back: accumulate, round, argmax
    dlm_back #(
        .COUNT_LIMIT (COUNT_LIMIT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head      (q_head),
        .pop       (q_pop),
        .relu_en   (relu_en_reg),
        .argmax_en (argmax_en_reg),
        .results   (results)
    );

    // queue never written when full
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("term queue written while full");

    // queue never read when empty
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("term queue read while empty");

    // a write without a read leaves the queue occupied
    a_push_occupies: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_pop) |=> !q_stat.empty)
        else $error("term queue lost a transfer");

endmodule
